/* hw/rtl/plac_pkg.sv */
// Package for the point light attenuation/cull core.
// Shared constants, status codes and pipeline sideband types. No dependencies.
package plac_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;
	localparam logic [15:0] ONE_Q15 = 16'd32768;

	typedef enum logic [1:0] {
		ST_CULL = 2'd0,
		ST_PASS = 2'd1,
		ST_DIR  = 2'd2
	} status_t;

	// Carried alongside the square root pipeline.
	typedef struct packed {
		logic        pass;
		logic        sat;
		logic        sx;
		logic        sy;
		logic        sz;
		logic [30:0] mx;
		logic [30:0] my;
		logic [30:0] mz;
		logic [30:0] fstart;
		logic [30:0] fend;
		logic [30:0] slope;
	} sqrt_sb_t;

	// Carried alongside the divider pipeline.
	typedef struct packed {
		logic        pass;
		logic        culled;
		logic        zero;
		logic        sx;
		logic        sy;
		logic        sz;
		logic [15:0] inten;
	} div_sb_t;

endpackage

/* hw/rtl/plac_sqrt.sv */
// Pipelined integer square root, one root bit per stage (32 stages).
// Depends on nothing; sideband of width SB_W travels with each request.
module plac_sqrt #(
	parameter int SB_W = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  logic [63:0]     in_val,
	input  logic [SB_W-1:0] in_sb,
	output logic            out_vld,
	output logic [31:0]     out_root,
	output logic [SB_W-1:0] out_sb
);
	localparam int N = 32;

	logic            vld_s [N+1];
	logic [63:0]     val_s [N+1];
	logic [33:0]     rem_s [N+1];
	logic [31:0]     root_s[N+1];
	logic [SB_W-1:0] sb_s  [N+1];

	assign vld_s[0]  = in_vld;
	assign val_s[0]  = in_val;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign sb_s[0]   = in_sb;

	for (genvar j = 0; j < N; j++) begin : g_stage
		localparam int B = N - 1 - j;
		logic [35:0] nxt;
		logic [35:0] trial;
		logic        ge;

		assign nxt   = {rem_s[j], val_s[j][2*B+1 -: 2]};
		assign trial = {2'b00, root_s[j], 2'b01};
		assign ge    = nxt >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			val_s[j+1]  <= val_s[j];
			sb_s[j+1]   <= sb_s[j];
			rem_s[j+1]  <= ge ? 34'(nxt - trial) : nxt[33:0];
			root_s[j+1] <= {root_s[j][30:0], ge};
		end
	end

	assign out_vld  = vld_s[N];
	assign out_root = root_s[N];
	assign out_sb   = sb_s[N];
endmodule

/* hw/rtl/plac_div.sv */
// Three-lane pipelined restoring divider, 16 quotient bits, one per stage.
// Numerator must be below divisor << 16. Sideband of width SB_W rides along.
module plac_div #(
	parameter int SB_W = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  logic [46:0]     in_num [3],
	input  logic [30:0]     in_den,
	input  logic [SB_W-1:0] in_sb,
	output logic            out_vld,
	output logic [15:0]     out_quo [3],
	output logic [SB_W-1:0] out_sb
);
	localparam int N = 16;

	logic            vld_s[N+1];
	logic [30:0]     den_s[N+1];
	logic [SB_W-1:0] sb_s [N+1];
	logic [15:0]     lo_s [3][N+1];
	logic [30:0]     rem_s[3][N+1];
	logic [15:0]     quo_s[3][N+1];

	assign vld_s[0] = in_vld;
	assign den_s[0] = in_den;
	assign sb_s[0]  = in_sb;

	for (genvar j = 0; j < N; j++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end
		always_ff @(posedge clk) begin
			den_s[j+1] <= den_s[j];
			sb_s[j+1]  <= sb_s[j];
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		assign lo_s[l][0]  = in_num[l][15:0];
		assign rem_s[l][0] = in_num[l][46:16];
		assign quo_s[l][0] = '0;

		for (genvar j = 0; j < N; j++) begin : g_stage
			logic [31:0] nxt;
			logic        ge;

			assign nxt = {rem_s[l][j], lo_s[l][j][N-1-j]};
			assign ge  = nxt >= {1'b0, den_s[j]};

			always_ff @(posedge clk) begin
				lo_s[l][j+1]  <= lo_s[l][j];
				rem_s[l][j+1] <= ge ? 31'(nxt - {1'b0, den_s[j]}) : nxt[30:0];
				quo_s[l][j+1] <= {quo_s[l][j][14:0], ge};
			end
		end

		assign out_quo[l] = quo_s[l][N];
	end

	assign out_vld = vld_s[N];
	assign out_sb  = sb_s[N];
endmodule

/* hw/rtl/point_light_attenuation_cull_core.sv */
// Point light attenuation and cull core: top level pipeline.
// Depends on plac_pkg, plac_sqrt and plac_div.
//
// One request is taken every clock cycle; busy stays low. Each request gives
// exactly one result, marked by done for one cycle, from these stages in order:
// 4 stages form the offset vector, magnitudes, squares and their sum, 32 stages
// take the square root one bit at a time, 4 stages form the distance, the cull
// test, the falloff product and intensity, 16 stages divide the three direction
// components one quotient bit at a time, and one stage drives the outputs.
// Results cannot be held off; the pipeline never stalls.
module point_light_attenuation_cull_core #(
	parameter int FRAC_BITS = plac_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [31:0]   object_x,
	input  logic signed [31:0]   object_y,
	input  logic signed [31:0]   object_z,
	input  logic signed [31:0]   light_x,
	input  logic signed [31:0]   light_y,
	input  logic signed [31:0]   light_z,
	input  logic [30:0]          falloff_start,
	input  logic [30:0]          falloff_end,
	input  logic [30:0]          falloff_slope,
	output logic                 done,
	output plac_pkg::status_t    status,
	output logic signed [15:0]   dir_x,
	output logic signed [15:0]   dir_y,
	output logic signed [15:0]   dir_z,
	output logic [15:0]          intensity
);
	import plac_pkg::*;

	localparam logic [33:0] HOFS = 34'(((64'd7 << FRAC_BITS) + 64'd3) / 64'd6);
	localparam int SH = 2 * FRAC_BITS - 15;
	localparam logic [62:0] HALF = 63'(64'd1 << (SH - 1));
	localparam int SSB_W = $bits(sqrt_sb_t);
	localparam int DSB_W = $bits(div_sb_t);

	assign busy = 1'b0;

	// s1: offset vector
	logic              v_s1, pass_s1;
	logic signed [33:0] dx_s1, dy_s1, dz_s1;
	logic [30:0]       fs_s1, fe_s1, sl_s1;
	logic              acc;

	assign acc = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		pass_s1 <= falloff_slope == '0;
		dx_s1   <= 34'(object_x) - 34'(light_x);
		dy_s1   <= 34'(object_y) - 34'(light_y);
		dz_s1   <= 34'(object_z) + $signed(HOFS) - 34'(light_z);
		fs_s1   <= falloff_start;
		fe_s1   <= falloff_end;
		sl_s1   <= falloff_slope;
	end

	// s2: magnitudes
	logic        v_s2;
	logic [33:0] ax, ay, az;
	sqrt_sb_t    sb_s2, sb_s3, sb_s4;

	assign ax = dx_s1[33] ? 34'(-dx_s1) : dx_s1;
	assign ay = dy_s1[33] ? 34'(-dy_s1) : dy_s1;
	assign az = dz_s1[33] ? 34'(-dz_s1) : dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sb_s2.pass   <= pass_s1;
		sb_s2.sat    <= (|ax[33:31]) || (|ay[33:31]) || (|az[33:31]);
		sb_s2.sx     <= dx_s1[33];
		sb_s2.sy     <= dy_s1[33];
		sb_s2.sz     <= dz_s1[33];
		sb_s2.mx     <= ax[30:0];
		sb_s2.my     <= ay[30:0];
		sb_s2.mz     <= az[30:0];
		sb_s2.fstart <= fs_s1;
		sb_s2.fend   <= fe_s1;
		sb_s2.slope  <= sl_s1;
	end

	// s3: squares
	logic        v_s3;
	logic [61:0] qx_s3, qy_s3, qz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		qx_s3 <= 62'(sb_s2.mx) * 62'(sb_s2.mx);
		qy_s3 <= 62'(sb_s2.my) * 62'(sb_s2.my);
		qz_s3 <= 62'(sb_s2.mz) * 62'(sb_s2.mz);
		sb_s3 <= sb_s2;
	end

	// s4: sum of squares
	logic        v_s4;
	logic [63:0] sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		sum_s4 <= 64'(qx_s3) + 64'(qy_s3) + 64'(qz_s3);
		sb_s4  <= sb_s3;
	end

	logic             v_r;
	logic [31:0]      root_r;
	logic [SSB_W-1:0] sbv_r;
	sqrt_sb_t         sb_r;

	plac_sqrt #(.SB_W(SSB_W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (v_s4),
		.in_val   (sum_s4),
		.in_sb    (SSB_W'(sb_s4)),
		.out_vld  (v_r),
		.out_root (root_r),
		.out_sb   (sbv_r)
	);

	assign sb_r = sqrt_sb_t'(sbv_r);

	// p1: saturated distance
	logic        v_p1;
	logic [30:0] dist_p1;
	sqrt_sb_t    sb_p1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
		end else begin
			v_p1 <= v_r;
		end
	end

	always_ff @(posedge clk) begin
		dist_p1 <= (sb_r.sat || root_r[31]) ? DIST_MAX : root_r[30:0];
		sb_p1   <= sb_r;
	end

	// p2: cull test, falloff offset
	logic        v_p2, culled_p2, below_p2, zero_p2;
	logic [30:0] dist_p2, diff_p2;
	sqrt_sb_t    sb_p2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p2 <= 1'b0;
		end else begin
			v_p2 <= v_p1;
		end
	end

	always_ff @(posedge clk) begin
		culled_p2 <= dist_p1 >= sb_p1.fend;
		below_p2  <= dist_p1 < sb_p1.fstart;
		zero_p2   <= dist_p1 == '0;
		diff_p2   <= dist_p1 - sb_p1.fstart;
		dist_p2   <= dist_p1;
		sb_p2     <= sb_p1;
	end

	// p3: falloff product
	logic        v_p3, culled_p3, below_p3, zero_p3;
	logic [30:0] dist_p3;
	logic [61:0] prod_p3;
	sqrt_sb_t    sb_p3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p3 <= 1'b0;
		end else begin
			v_p3 <= v_p2;
		end
	end

	always_ff @(posedge clk) begin
		prod_p3   <= 62'(diff_p2) * 62'(sb_p2.slope);
		culled_p3 <= culled_p2;
		below_p3  <= below_p2;
		zero_p3   <= zero_p2;
		dist_p3   <= dist_p2;
		sb_p3     <= sb_p2;
	end

	// p4: intensity and divider numerators
	logic        v_p4;
	logic [30:0] dist_p4;
	logic [46:0] num_p4 [3];
	div_sb_t     dsb_p4;
	logic [62:0] rq;
	logic [15:0] inten_c;

	always_comb begin
		rq = (63'(prod_p3) + HALF) >> SH;
		if (below_p3) begin
			inten_c = ONE_Q15;
		end else if (rq >= 63'(ONE_Q15)) begin
			inten_c = '0;
		end else begin
			inten_c = ONE_Q15 - rq[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p4 <= 1'b0;
		end else begin
			v_p4 <= v_p3;
		end
	end

	always_ff @(posedge clk) begin
		dist_p4       <= dist_p3;
		num_p4[0]     <= {sb_p3.mx, 15'd0} + 47'(dist_p3[30:1]);
		num_p4[1]     <= {sb_p3.my, 15'd0} + 47'(dist_p3[30:1]);
		num_p4[2]     <= {sb_p3.mz, 15'd0} + 47'(dist_p3[30:1]);
		dsb_p4.pass   <= sb_p3.pass;
		dsb_p4.culled <= culled_p3;
		dsb_p4.zero   <= zero_p3;
		dsb_p4.sx     <= sb_p3.sx;
		dsb_p4.sy     <= sb_p3.sy;
		dsb_p4.sz     <= sb_p3.sz;
		dsb_p4.inten  <= inten_c;
	end

	logic             v_d;
	logic [15:0]      quo_d [3];
	logic [DSB_W-1:0] dsbv_d;
	div_sb_t          dsb_d;

	plac_div #(.SB_W(DSB_W)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (v_p4),
		.in_num  (num_p4),
		.in_den  (dist_p4),
		.in_sb   (DSB_W'(dsb_p4)),
		.out_vld (v_d),
		.out_quo (quo_d),
		.out_sb  (dsbv_d)
	);

	assign dsb_d = div_sb_t'(dsbv_d);

	// output stage
	function automatic logic [15:0] sgn_sat(input logic neg, input logic [15:0] q);
		logic [15:0] r;
		if (neg) begin
			r = (q > ONE_Q15) ? ONE_Q15 : 16'(-q);
		end else begin
			r = (q > 16'd32767) ? 16'd32767 : q;
		end
		return r;
	endfunction

	logic dir_ok;
	assign dir_ok = !dsb_d.pass && !dsb_d.culled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (dsb_d.pass) begin
			status <= ST_PASS;
		end else if (dsb_d.culled) begin
			status <= ST_CULL;
		end else begin
			status <= ST_DIR;
		end
		if (dir_ok && !dsb_d.zero) begin
			dir_x <= sgn_sat(dsb_d.sx, quo_d[0]);
			dir_y <= sgn_sat(dsb_d.sy, quo_d[1]);
			dir_z <= sgn_sat(dsb_d.sz, quo_d[2]);
		end else begin
			dir_x <= '0;
			dir_y <= '0;
			dir_z <= '0;
		end
		intensity <= dir_ok ? dsb_d.inten : '0;
	end
endmodule
